>>> rtl/upward_expander_gain_stage_unit_assert.svh
// ----------------------------------------------------------------------------
// upward expander assertion macros
// concurrent checks for the top rtl file, clocked on clk_i, off in reset
// ----------------------------------------------------------------------------
`ifndef UPWARD_EXPANDER_GAIN_STAGE_UNIT_ASSERT_SVH
`define UPWARD_EXPANDER_GAIN_STAGE_UNIT_ASSERT_SVH

// same-cycle implication
`define UEGS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uegs check failed");

// next-cycle implication
`define UEGS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uegs check failed");

`endif

>>> rtl/uegs_pkg.sv
// ----------------------------------------------------------------------------
// uegs_pkg
// shared types, constants and root table of the upward expander gain stage
// ----------------------------------------------------------------------------
`default_nettype none

package uegs_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int CH_W         = 3;
  localparam int IDX_W        = $clog2(NUM_CHANNELS);
  localparam int GAIN_W       = 23;
  localparam int OP_W         = 33;
  localparam int PR_W         = 2 * OP_W;
  localparam int CFG_IDX_W    = 4;

  localparam logic [GAIN_W-1:0]   GAIN_UNITY  = 23'd65536;
  localparam logic [GAIN_W-1:0]   GAIN_MAX    = 23'd6553600;
  localparam logic signed [16:0]  DB_FLOOR    = -17'sd20480;
  localparam logic signed [16:0]  DB_CEIL     = 17'sd32767;
  localparam logic signed [21:0]  GR_LIM      = 22'sd1048576;
  localparam logic signed [32:0]  DB_PER_LOG2 = 33'sd394566;
  localparam logic signed [32:0]  LOG2_PER_DB = 33'sd2786635;
  localparam logic [40:0]         TGT_MAX     = 41'h100_0000_0000;
  localparam logic [40:0]         TGT_SAT     = 41'(6553601) << 16;
  localparam logic [15:0]         MIX_FULL    = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH = 4'd0,
    REG_KSTART = 4'd1,
    REG_KEND   = 4'd2,
    REG_RANGE  = 4'd3,
    REG_SLOPE  = 4'd4,
    REG_KNEE   = 4'd5,
    REG_MAKEUP = 4'd6,
    REG_MIX    = 4'd7
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FB0, ST_FB1, ST_FB2, ST_NORM, ST_SQR, ST_SQW, ST_L2, ST_L2W,
    ST_GC0, ST_GCL, ST_GCK0, ST_GCK1, ST_EXP, ST_EXPW, ST_ROOT, ST_ROOTW,
    ST_SHIFT, ST_EN0, ST_EN1, ST_EN2, ST_EN3, ST_EN4,
    ST_OU0, ST_OU1, ST_OU2, ST_OU3, ST_OU4, ST_OU5, ST_OU6, ST_RES
  } state_e;

  typedef struct packed {
    logic [31:0]        coeffs;
    logic signed [15:0] knee_start;
    logic signed [15:0] knee_end;
    logic signed [15:0] range_db;
    logic [15:0]        slope;
    logic [15:0]        knee_coeff;
    logic [23:0]        makeup;
    logic [15:0]        mix;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CH_W-1:0]               channel;
    logic [GAIN_W-1:0]             gain;
  } res_t;

  function automatic logic signed [OP_W-1:0] uop(input logic [31:0] v);
    return $signed({1'b0, v});
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    vv = v;
    for (int k = 0; k < 32; k++) begin
      if (b > vv) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (vv >= r + b) begin
          vv = vv - (r + b);
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-n) in q1.30
  function automatic logic [31:0] root_at(input int n);
    logic [63:0] root;
    root = 64'd2 << 30;
    for (int k = 1; k <= 16; k++) begin
      if (k <= n) root = isqrt64(root << 30);
    end
    return root[31:0];
  endfunction

  localparam logic [31:0] ROOT_TAB [16] = '{
    root_at(1),  root_at(2),  root_at(3),  root_at(4),
    root_at(5),  root_at(6),  root_at(7),  root_at(8),
    root_at(9),  root_at(10), root_at(11), root_at(12),
    root_at(13), root_at(14), root_at(15), root_at(16)
  };

endpackage

`default_nettype wire

>>> rtl/uegs_mul.sv
// ----------------------------------------------------------------------------
// uegs_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module uegs_mul import uegs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic signed [OP_W-1:0] a_i,
  input  wire logic signed [OP_W-1:0] b_i,
  output logic signed [PR_W-1:0]      p_o
);

  logic signed [PR_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> rtl/uegs_core.sv
// ----------------------------------------------------------------------------
// uegs_core
// sequencer and datapath: detector, log, gain computer, exp, envelope, mix
// ----------------------------------------------------------------------------
`default_nettype none

module uegs_core import uegs_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [CH_W-1:0]               channel_i,
  input  wire logic                          ff_i,
  input  wire cfg_t                          cfg_i,
  output logic                               ready_o,
  output logic                               res_valid_o,
  output res_t                               res_o,
  input  wire logic                          res_take_i
);

  state_e state_q, state_d;

  logic [GAIN_W-1:0]      env_q [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0] as_q;
  logic                   neg_q;
  logic                   ff_q;
  logic [CH_W-1:0]        ch_q;
  logic [IDX_W-1:0]       idx_q;
  logic [46:0]            pm_q;
  logic [39:0]            mag_q;
  logic [5:0]             pos_q;
  logic [31:0]            x_q;
  logic [15:0]            frac_q;
  logic [3:0]             cnt_q;
  logic signed [16:0]     db_q;
  logic signed [21:0]     gr_q;
  logic signed [11:0]     ip_q;
  logic [15:0]            f_q;
  logic [31:0]            acc_q;
  logic [40:0]            tgt_q;
  logic [15:0]            alpha_q;
  logic [57:0]            sum_q;
  logic [GAIN_W-1:0]      nenv_q;
  logic [47:0]            g_q;
  logic [73:0]            s_q;

  logic signed [OP_W-1:0] mul_a, mul_b;
  logic signed [PR_W-1:0] prod;

  logic [GAIN_W-1:0]      env_rd;
  logic [39:0]            mag_w;
  logic [31:0]            t_sq;
  logic signed [22:0]     l2_w;
  logic signed [41:0]     dbr_w;
  logic signed [17:0]     rmd_w;
  logic signed [17:0]     d_w;
  logic                   below_ks, below_ke;
  logic signed [51:0]     glin_w;
  logic signed [45:0]     gk_w;
  logic [40:0]            shl_w;
  logic [40:0]            tgt_w;
  logic [40:0]            tcl_w;
  logic signed [11:0]     rsh_w;
  logic [16:0]            bco_w;
  logic [41:0]            nraw_w;
  logic [GAIN_W-1:0]      nenv_w;
  logic [15:0]            mixv;
  logic [42:0]            m_w;
  logic [SAMPLE_BITS-1:0] lim_w;
  logic [SAMPLE_BITS-1:0] mo_w;

  uegs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign env_rd   = env_q[idx_q];
  assign mag_w    = ff_q ? {16'b0, as_q} : {1'b0, prod[54:16]};
  assign t_sq     = prod[61:30];
  assign l2_w     = $signed({1'b0, pos_q, frac_q}) - $signed(23'((SAMPLE_BITS - 1) << 16));
  assign dbr_w    = $signed(prod[65:24]);
  assign rmd_w    = 18'($signed(cfg_i.range_db)) - 18'(db_q);
  assign d_w      = 18'($signed(cfg_i.knee_end)) - 18'(db_q);
  assign below_ks = db_q < 17'($signed(cfg_i.knee_start));
  assign below_ke = db_q < 17'($signed(cfg_i.knee_end));
  assign glin_w   = $signed(prod[65:14]);
  assign gk_w     = $signed(prod[65:20]);
  assign mixv     = (cfg_i.mix > MIX_FULL) ? MIX_FULL : cfg_i.mix;
  assign bco_w    = 17'(17'd65536 - {1'b0, alpha_q});
  assign nraw_w   = sum_q[57:16];
  assign nenv_w   = (nraw_w > 42'(GAIN_MAX)) ? GAIN_MAX : nraw_w[GAIN_W-1:0];
  assign shl_w    = {9'b0, acc_q} << 4'(ip_q - 12'sd14);
  assign rsh_w    = 12'sd14 - ip_q;

  always_comb begin
    if (ip_q >= 12'sd14) begin
      if (ip_q >= 12'sd24) begin
        tgt_w = TGT_MAX;
      end else begin
        tgt_w = (shl_w > TGT_MAX) ? TGT_MAX : shl_w;
      end
    end else if (rsh_w >= 12'sd32) begin
      tgt_w = '0;
    end else begin
      tgt_w = {9'b0, acc_q >> rsh_w[4:0]};
    end
    tcl_w = (tgt_w > TGT_SAT) ? TGT_SAT : tgt_w;
  end

  assign m_w   = s_q[73:31];
  assign lim_w = neg_q ? 24'h80_0000 : 24'h7F_FFFF;
  assign mo_w  = (m_w > 43'(lim_w)) ? lim_w : m_w[SAMPLE_BITS-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_FB0;
      ST_FB0:   state_d = ST_FB1;
      ST_FB1:   state_d = ST_FB2;
      ST_FB2:   state_d = (mag_w == '0) ? ST_GC0 : ST_NORM;
      ST_NORM:  if (mag_q[39]) state_d = ST_SQR;
      ST_SQR:   state_d = ST_SQW;
      ST_SQW:   state_d = (cnt_q == 4'd15) ? ST_L2 : ST_SQR;
      ST_L2:    state_d = ST_L2W;
      ST_L2W:   state_d = ST_GC0;
      ST_GC0: begin
        if (below_ks)      state_d = ST_GCL;
        else if (below_ke) state_d = ST_GCK0;
        else               state_d = ST_EXP;
      end
      ST_GCL:   state_d = ST_EXP;
      ST_GCK0:  state_d = ST_GCK1;
      ST_GCK1:  state_d = ST_EXP;
      ST_EXP:   state_d = ST_EXPW;
      ST_EXPW:  state_d = ST_ROOT;
      ST_ROOT:  state_d = ST_ROOTW;
      ST_ROOTW: state_d = (cnt_q == 4'd15) ? ST_SHIFT : ST_ROOT;
      ST_SHIFT: state_d = ST_EN0;
      ST_EN0:   state_d = ST_EN1;
      ST_EN1:   state_d = ST_EN2;
      ST_EN2:   state_d = ST_EN3;
      ST_EN3:   state_d = ST_EN4;
      ST_EN4:   state_d = ST_OU0;
      ST_OU0:   state_d = ST_OU1;
      ST_OU1:   state_d = ST_OU2;
      ST_OU2:   state_d = ST_OU3;
      ST_OU3:   state_d = ST_OU4;
      ST_OU4:   state_d = ST_OU5;
      ST_OU5:   state_d = ST_OU6;
      ST_OU6:   state_d = ST_RES;
      ST_RES:   if (res_take_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // multiplier operands and handshake
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    ready_o     = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_RES);
    case (state_q)
      ST_FB0:  begin mul_a = uop(32'(env_rd)); mul_b = uop(32'(cfg_i.makeup)); end
      ST_FB1:  begin mul_a = uop(32'(as_q));   mul_b = uop(32'(prod[46:16]));  end
      ST_SQR:  begin mul_a = uop(x_q);         mul_b = uop(x_q);               end
      ST_L2:   begin mul_a = 33'(l2_w);        mul_b = DB_PER_LOG2;            end
      ST_GC0: begin
        if (below_ks) begin
          mul_a = 33'(rmd_w);
          mul_b = uop(32'(cfg_i.slope));
        end else begin
          mul_a = 33'(d_w);
          mul_b = 33'(d_w);
        end
      end
      ST_GCK0: begin mul_a = uop(32'(cfg_i.knee_coeff)); mul_b = uop(prod[31:0]); end
      ST_EXP:  begin mul_a = 33'(gr_q);        mul_b = LOG2_PER_DB;            end
      ST_ROOT: begin mul_a = uop(acc_q);       mul_b = uop(ROOT_TAB[cnt_q]);   end
      ST_EN0:  begin mul_a = uop(32'(alpha_q)); mul_b = uop(32'(env_rd));      end
      ST_EN1:  begin mul_a = uop(32'(bco_w));  mul_b = uop(32'(tgt_q[15:0]));  end
      ST_EN2:  begin mul_a = uop(32'(bco_w));  mul_b = uop(32'(tgt_q[38:16])); end
      ST_OU0:  begin mul_a = uop(32'(nenv_q)); mul_b = uop(32'(cfg_i.makeup)); end
      ST_OU1:  begin mul_a = uop(32'(prod[46:16])); mul_b = uop(32'(mixv));    end
      ST_OU2:  begin mul_a = uop(32'(pm_q[15:0])); mul_b = uop(32'(mixv));     end
      ST_OU4:  begin mul_a = uop(32'(as_q));   mul_b = uop(32'(g_q[23:0]));    end
      ST_OU5:  begin mul_a = uop(32'(as_q));   mul_b = uop(32'(g_q[47:24]));   end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < NUM_CHANNELS; i++) env_q[i] <= GAIN_UNITY;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EN4) env_q[idx_q] <= nenv_w;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          as_q  <= sample_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_i) : SAMPLE_BITS'(sample_i);
          neg_q <= sample_i[SAMPLE_BITS-1];
          ff_q  <= ff_i;
          ch_q  <= channel_i;
          idx_q <= IDX_W'(channel_i);
        end
      end
      ST_FB2: begin
        mag_q <= mag_w;
        pos_q <= 6'd39;
        db_q  <= DB_FLOOR;
      end
      ST_NORM: begin
        if (mag_q[39]) begin
          x_q    <= {1'b0, mag_q[39:9]};
          frac_q <= '0;
          cnt_q  <= '0;
        end else begin
          mag_q <= mag_q << 1;
          pos_q <= pos_q - 6'd1;
        end
      end
      ST_SQW: begin
        x_q    <= t_sq[31] ? {1'b0, t_sq[31:1]} : t_sq;
        frac_q <= {frac_q[14:0], t_sq[31]};
        cnt_q  <= cnt_q + 4'd1;
      end
      ST_L2W: begin
        if (dbr_w < 42'(DB_FLOOR))     db_q <= DB_FLOOR;
        else if (dbr_w > 42'(DB_CEIL)) db_q <= DB_CEIL;
        else                           db_q <= dbr_w[16:0];
      end
      ST_GC0: gr_q <= '0;
      ST_GCL: begin
        if (glin_w > 52'(GR_LIM))       gr_q <= GR_LIM;
        else if (glin_w < -52'(GR_LIM)) gr_q <= -GR_LIM;
        else                            gr_q <= glin_w[21:0];
      end
      ST_GCK1: gr_q <= (gk_w > 46'(GR_LIM)) ? GR_LIM : gk_w[21:0];
      ST_EXPW: begin
        ip_q  <= $signed(prod[43:32]);
        f_q   <= prod[31:16];
        acc_q <= 32'h4000_0000;
        cnt_q <= '0;
      end
      ST_ROOTW: begin
        if (f_q[4'(4'd15 - cnt_q)]) acc_q <= prod[61:30];
        cnt_q <= cnt_q + 4'd1;
      end
      ST_SHIFT: begin
        tgt_q   <= tcl_w;
        alpha_q <= (tgt_w > 41'(env_rd)) ? cfg_i.coeffs[31:16] : cfg_i.coeffs[15:0];
      end
      ST_EN1: sum_q <= prod[57:0];
      ST_EN2: sum_q <= sum_q + prod[57:0];
      ST_EN3: sum_q <= sum_q + {prod[41:0], 16'b0};
      ST_EN4: nenv_q <= nenv_w;
      ST_OU1: pm_q <= prod[46:0];
      ST_OU2: g_q <= prod[47:0];
      ST_OU3: g_q <= g_q + 48'(prod[31:16]) + {16'b0, 16'(MIX_FULL - mixv), 16'b0};
      ST_OU5: s_q <= 74'(prod[47:0]);
      ST_OU6: s_q <= s_q + {2'b0, prod[47:0], 24'b0};
      default: ;
    endcase
  end

  assign res_o.sample  = neg_q ? $signed(SAMPLE_BITS'(-mo_w)) : $signed(mo_w);
  assign res_o.channel = ch_q;
  assign res_o.gain    = nenv_q;

endmodule

`default_nettype wire

>>> rtl/upward_expander_gain_stage_unit.sv
// ----------------------------------------------------------------------------
// upward_expander_gain_stage_unit
// per-channel soft-knee upward expander with shared-multiplier sequencer
// ----------------------------------------------------------------------------
//  channel   dir  tdata / payload                        tuser
//  s_axis    in   [23:0] sample_in                       [2:0] channel, [3] feed_forward
//  m_axis    out  [23:0] sample_out, [46:24] gain_now    [2:0] out_channel
//  cfg       in   cfg_index_i register, cfg_data_i value -
//
//  all products go through one 33x33 multiplier; the level normalize shifts
//  one bit a cycle, and the log and exp steps loop on the multiplier
//  s_axis_tready is high only while the sequencer is idle; a finished item
//  waits in the output register, so the next item is taken while it stalls
//  reset sets all channel gains to unity and registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module upward_expander_gain_stage_unit import uegs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [SAMPLE_BITS-1:0] s_axis_tdata,   // sample_in
  input  wire logic [3:0]             s_axis_tuser,   // channel, feed_forward
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [47:0]                 m_axis_tdata,   // sample_out, gain_now, pad
  output logic [CH_W-1:0]             m_axis_tuser,   // out_channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]            cfg_data_i
);

  `include "upward_expander_gain_stage_unit_assert.svh"

  cfg_t cfg_q;
  logic core_ready, res_valid, res_take;
  res_t res;
  res_t out_q;
  logic out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeffs     <= 32'hFFFF_0000;
      cfg_q.knee_start <= -16'sd10240;
      cfg_q.knee_end   <= -16'sd9728;
      cfg_q.range_db   <= -16'sd10240;
      cfg_q.slope      <= 16'd8192;
      cfg_q.knee_coeff <= 16'd2048;
      cfg_q.makeup     <= 24'd65536;
      cfg_q.mix        <= 16'd32768;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SMOOTH: cfg_q.coeffs     <= cfg_data_i;
        REG_KSTART: cfg_q.knee_start <= $signed(cfg_data_i[15:0]);
        REG_KEND:   cfg_q.knee_end   <= $signed(cfg_data_i[15:0]);
        REG_RANGE:  cfg_q.range_db   <= $signed(cfg_data_i[15:0]);
        REG_SLOPE:  cfg_q.slope      <= cfg_data_i[15:0];
        REG_KNEE:   cfg_q.knee_coeff <= cfg_data_i[15:0];
        REG_MAKEUP: cfg_q.makeup     <= cfg_data_i[23:0];
        REG_MIX:    cfg_q.mix        <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  uegs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && s_axis_tready),
    .sample_i    ($signed(s_axis_tdata)),
    .channel_i   (s_axis_tuser[2:0]),
    .ff_i        (s_axis_tuser[3]),
    .cfg_i       (cfg_q),
    .ready_o     (core_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign s_axis_tready = core_ready;
  assign res_take      = res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.gain, out_q.sample};
  assign m_axis_tuser  = out_q.channel;

  `UEGS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `UEGS_ASSERT_NOW(a_gain_in_range, m_axis_tvalid, m_axis_tdata[46:24] <= 23'd6553600)
  `UEGS_ASSERT_NOW(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the upward expander gain stage: a scoreboard
// predicts every output item from the accepted input items and the current
// register settings, and compares it field by field. Random input and output
// gaps, several register settings per run, including the extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import uegs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;

  class expander_scoreboard;
    bit [63:0] env_q[NUM_CHANNELS];
    bit [31:0] regs[8];
    bit [SAMPLE_BITS-1:0] exp_sample[$];
    bit [CH_W-1:0]        exp_channel[$];
    bit [GAIN_W-1:0]      exp_gain[$];
    int errors;

    function new();
      for (int i = 0; i < NUM_CHANNELS; i++) env_q[i] = 65536;
      regs[REG_SMOOTH] = 32'hFFFF_0000;
      regs[REG_KSTART] = 32'(16'hD800);
      regs[REG_KEND]   = 32'(16'hDA00);
      regs[REG_RANGE]  = 32'(16'hD800);
      regs[REG_SLOPE]  = 8192;
      regs[REG_KNEE]   = 2048;
      regs[REG_MAKEUP] = 65536;
      regs[REG_MIX]    = 32768;
      errors = 0;
    endfunction

    function void write_reg(bit [3:0] idx, bit [31:0] val);
      if (idx == REG_SMOOTH) regs[idx] = val;
      else if (idx == REG_MAKEUP) regs[idx] = val & 32'hFF_FFFF;
      else if (idx < 8) regs[idx] = val & 32'hFFFF;
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint level_in_db(bit [63:0] mag);
      int p;
      bit [63:0] x;
      bit [63:0] frac;
      longint l2;
      longint db;
      if (mag == 0) return -20480;
      p = 63;
      while (mag[p] == 0) p--;
      x = (p >= 30) ? (mag >> (p - 30)) : (mag << (30 - p));
      frac = 0;
      for (int i = 0; i < 16; i++) begin
        x = (x * x) >> 30;
        frac = frac << 1;
        if (x >= (64'd1 << 31)) begin
          frac = frac | 1;
          x = x >> 1;
        end
      end
      l2 = longint'((64'(p) << 16) | frac) - (longint'(SAMPLE_BITS - 1) << 16);
      db = (l2 * 394566) >>> 24;
      if (db < -20480) db = -20480;
      if (db > 32767) db = 32767;
      return db;
    endfunction

    function bit [63:0] db_to_linear(longint gr);
      longint e;
      longint ip;
      bit [63:0] f;
      bit [63:0] acc;
      bit [63:0] root;
      e = (gr * 2786635) >>> 16;
      ip = e >>> 16;
      f = 64'(e) & 64'hFFFF;
      acc = 64'd1 << 30;
      root = 64'd2 << 30;
      for (int i = 1; i <= 16; i++) begin
        root = int_sqrt(root << 30);
        if (f[16 - i]) acc = (acc * root) >> 30;
      end
      if (ip >= 14) begin
        if (ip - 14 >= 10) return 64'd1 << 40;
        acc = acc << (ip - 14);
        return (acc > (64'd1 << 40)) ? (64'd1 << 40) : acc;
      end
      if (14 - ip >= 63) return 0;
      return acc >> (14 - ip);
    endfunction

    function void note_input(bit [SAMPLE_BITS-1:0] smp, bit [CH_W-1:0] ch, bit ff);
      longint s, db, gr, ks, ke, rg, d;
      bit [63:0] as, env, mk, mixv, mag, tgt, alpha, g, lim, m;
      bit [127:0] prod;
      int idx;
      s = longint'($signed(smp));
      idx = ch % NUM_CHANNELS;
      env = env_q[idx];
      mk = regs[REG_MAKEUP];
      mixv = (regs[REG_MIX] > 32768) ? 32768 : regs[REG_MIX];
      as = (s < 0) ? 64'(-s) : 64'(s);
      ks = longint'($signed(regs[REG_KSTART][15:0]));
      ke = longint'($signed(regs[REG_KEND][15:0]));
      rg = longint'($signed(regs[REG_RANGE][15:0]));
      mag = ff ? as : ((as * ((env * mk) >> 16)) >> 16);
      db = level_in_db(mag);
      gr = 0;
      if (db < ks) begin
        gr = ((rg - db) * longint'(regs[REG_SLOPE])) >>> 16'd14;
      end else if (db < ke) begin
        d = ke - db;
        gr = longint'((64'(regs[REG_KNEE]) * 64'(d * d)) >> 20);
      end
      if (gr > (64'sd1 <<< 20)) gr = 64'sd1 <<< 20;
      if (gr < -(64'sd1 <<< 20)) gr = -(64'sd1 <<< 20);
      tgt = db_to_linear(gr);
      alpha = (tgt > env) ? (regs[REG_SMOOTH] >> 16) : (regs[REG_SMOOTH] & 32'hFFFF);
      env = (alpha * env + (65536 - alpha) * tgt) >> 16;
      if (env > 6553600) env = 6553600;
      env_q[idx] = env;
      g = (env * mk * mixv + ((32768 - mixv) << 32)) >> 16;
      lim = (s < 0) ? (64'd1 << (SAMPLE_BITS - 1)) : ((64'd1 << (SAMPLE_BITS - 1)) - 1);
      prod = (128'(as) * 128'(g)) >> 31;
      m = (prod > 128'(lim)) ? lim : prod[63:0];
      exp_sample.push_back((s < 0) ? SAMPLE_BITS'(-m) : SAMPLE_BITS'(m));
      exp_channel.push_back(ch);
      exp_gain.push_back(env[GAIN_W-1:0]);
    endfunction

    function void check_output(bit [47:0] data, bit [CH_W-1:0] user);
      bit [SAMPLE_BITS-1:0] es;
      bit [CH_W-1:0] ec;
      bit [GAIN_W-1:0] eg;
      if (exp_sample.size() == 0) begin
        $error("unexpected output item tdata=%h tuser=%h", data, user);
        errors++;
        return;
      end
      es = exp_sample.pop_front();
      ec = exp_channel.pop_front();
      eg = exp_gain.pop_front();
      if (data[23:0] !== es) begin
        $error("sample_out expected %0d actual %0d", $signed(es), $signed(data[23:0]));
        errors++;
      end
      if (data[46:24] !== eg) begin
        $error("gain_now expected %0d actual %0d", eg, data[46:24]);
        errors++;
      end
      if (user !== ec) begin
        $error("out_channel expected %0d actual %0d", ec, user);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [SAMPLE_BITS-1:0] s_axis_tdata = '0;
  logic [3:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [47:0] m_axis_tdata;
  logic [CH_W-1:0] m_axis_tuser;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  expander_scoreboard sb = new();
  bit no_gaps = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  upward_expander_gain_stage_unit u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL upward_expander_gain_stage_unit");
      $finish;
    end
  end

  task automatic write_cfg(bit [3:0] idx, bit [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1;
    cfg_index_i = idx;
    cfg_data_i = val;
    #1;
    while (!cfg_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic send_sample(bit [SAMPLE_BITS-1:0] smp, bit [CH_W-1:0] ch, bit ff);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(13);
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1;
    s_axis_tdata = smp;
    s_axis_tuser = {ff, ch};
    #1;
    while (!s_axis_tready) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    sb.note_input(smp, ch, ff);
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic drain();
    while (sb.exp_sample.size() != 0) @(posedge clk_i);
  endtask

  function automatic bit [SAMPLE_BITS-1:0] rand_sample();
    bit [SAMPLE_BITS-1:0] v;
    v = 24'($urandom);
    case ($urandom_range(3))
      0: return v;
      1: return $signed(v) >>> $urandom_range(23);
      2: return v >> $urandom_range(23);
      default: return ($urandom_range(1) ? v : 24'(-v)) >> $urandom_range(4, 20);
    endcase
  endfunction

  task automatic random_cfg();
    int ks;
    ks = -$urandom_range(20480);
    write_cfg(REG_SMOOTH, $urandom_range(1) ? $urandom : {16'($urandom_range(65535, 50000)),
                                                          16'($urandom_range(65535, 50000))});
    write_cfg(REG_KSTART, 32'(16'(ks)));
    write_cfg(REG_KEND, $urandom_range(3) == 0 ? $urandom : 32'(16'(ks + $urandom_range(3000))));
    write_cfg(REG_RANGE, $urandom_range(1) ? $urandom : 32'(16'(-$urandom_range(20480))));
    write_cfg(REG_SLOPE, $urandom_range(1) ? $urandom : $urandom_range(20000));
    write_cfg(REG_KNEE, $urandom);
    write_cfg(REG_MAKEUP, $urandom_range(1) ? $urandom : $urandom_range(200000));
    write_cfg(REG_MIX, $urandom_range(3) == 0 ? $urandom : $urandom_range(32768));
  endtask

  initial begin
    forever begin
      int stall;
      stall = no_gaps ? 0 : $urandom_range(13);
      @(negedge clk_i);
      m_axis_tready = 0;
      repeat (stall) @(negedge clk_i);
      m_axis_tready = 1;
      #1;
      while (!m_axis_tvalid) begin
        @(negedge clk_i);
        #1;
      end
      @(posedge clk_i);
      sb.check_output(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed items with reset settings
    send_sample(24'h000000, 0, 1);
    send_sample(24'h7FFFFF, 1, 1);
    send_sample(24'h800000, 2, 1);
    send_sample(24'hFFFFFF, 3, 0);
    send_sample(24'h000001, 4, 0);
    send_sample(24'h000100, 5, 1);
    send_sample(24'h7FFFFF, 6, 0);
    send_sample(24'h800000, 7, 0);
    drain();
    // extremes: all zero, then all ones, plus ignored indexes
    for (int r = 0; r < 8; r++) write_cfg(4'(r), 0);
    write_cfg(4'd8, 32'hFFFF_FFFF);
    write_cfg(4'd15, 32'hFFFF_FFFF);
    send_sample(24'h400000, 0, 1);
    send_sample(24'h000000, 1, 0);
    send_sample(24'hC00000, 2, 0);
    drain();
    for (int r = 0; r < 8; r++) write_cfg(4'(r), 32'hFFFF_FFFF);
    send_sample(24'h7FFFFF, 0, 1);
    send_sample(24'h800000, 0, 0);
    send_sample(24'h000010, 7, 1);
    send_sample(24'h123456, 3, 0);
    drain();
    write_cfg(REG_MIX, 16384);
    write_cfg(REG_MAKEUP, 32'hFF_FFFF);
    write_cfg(REG_SMOOTH, 32'h8000_8000);
    send_sample(24'h7FFFFF, 5, 1);
    send_sample(24'h800000, 5, 0);
    send_sample(24'h000003, 6, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_cfg();
      no_gaps = (ph % 3 == 2);
      for (int n = 0; n < 50; n++)
        send_sample(rand_sample(), 3'($urandom_range(7)), 1'($urandom_range(1)));
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.exp_sample.size() == 0) begin
      $display("PASS upward_expander_gain_stage_unit");
    end else begin
      $display("FAIL upward_expander_gain_stage_unit");
    end
    $finish;
  end
endmodule

`default_nettype wire
